@@ sv/ipd_pkg.sv @@
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared widths, command codes, defaults and control types of the IR
// presence detector.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int CMD_W    = 2;
    localparam int SENSOR_W = 5;
    localparam int SAMPLE_W = 10;
    localparam int THRESH_W = 10;
    localparam int SUM_W    = 16;
    localparam int OUT_W    = 24;

    localparam int DEF_NUM_SENSORS   = 24;
    localparam int DEF_CAL_PASSES    = 16;
    localparam int DEF_HISTORY_DEPTH = 5;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(110);
    localparam logic [SUM_W-1:0]    SUM_MAX      = '1;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DETECT = 2'd2;

    typedef struct packed {
        logic upd;
        logic det;
        logic close;
    } t_frame_op;

endpackage

@@ sv/ipd_if.sv @@
// ----------------------------------------------------------------------------
// ipd_in_if / ipd_out_if
// Valid/ready channels carrying sample words in and frame result words out.
// ----------------------------------------------------------------------------
interface ipd_in_if
    import ipd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SENSOR_W-1:0] sensor_index;
    logic [SAMPLE_W-1:0] sample_value;
    logic                frame_end;

    modport source (output valid, cmd, sensor_index, sample_value, frame_end,
                    input ready);
    modport sink   (input valid, cmd, sensor_index, sample_value, frame_end,
                    output ready);
endinterface

interface ipd_out_if
    import ipd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] detected_bits;
    logic [OUT_W-1:0] raw_frame_bits;

    modport source (output valid, detected_bits, raw_frame_bits, input ready);
    modport sink   (input valid, detected_bits, raw_frame_bits, output ready);
endinterface

@@ sv/ipd_sum_ram.sv @@
// ----------------------------------------------------------------------------
// ipd_sum_ram
// Baseline sum memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ipd_sum_ram
    import ipd_pkg::*;
#(
    parameter int DEPTH  = DEF_NUM_SENSORS,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [SUM_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [SUM_W-1:0]  o_rd_data
);

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/ipd_frame.sv @@
// ----------------------------------------------------------------------------
// ipd_frame
// Current frame bits, frame history shift line and the result output
// register.
// ----------------------------------------------------------------------------
module ipd_frame
    import ipd_pkg::*;
#(
    parameter int NUM_SENSORS   = DEF_NUM_SENSORS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_frame_op              i_op,
    input  logic [NUM_SENSORS-1:0] i_mask,
    output logic                   o_free,
    ipd_out_if.source              o_result
);

    logic [NUM_SENSORS-1:0] r_frame;
    logic [NUM_SENSORS-1:0] n_frame;
    logic [NUM_SENSORS-1:0] r_hist [HISTORY_DEPTH];
    logic [NUM_SENSORS-1:0] acc;
    logic [OUT_W-1:0]       raw_w;
    logic [OUT_W-1:0]       acc_w;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_det;
    logic [OUT_W-1:0]       r_out_raw;

    always_comb begin
        n_frame = r_frame;
        if (i_op.upd) begin
            n_frame = i_op.det ? (r_frame | i_mask) : (r_frame & ~i_mask);
        end
        acc = n_frame;
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            acc = acc | r_hist[i];
        end
    end

    for (genvar g = 0; g < OUT_W; g++) begin : g_widen
        if (g < NUM_SENSORS) begin : g_bit
            assign raw_w[g] = n_frame[g];
            assign acc_w[g] = acc[g];
        end else begin : g_zero
            assign raw_w[g] = 1'b0;
            assign acc_w[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_op.close) begin
            r_frame  <= '0;
            r_hist[0] <= n_frame;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end else begin
            r_frame <= n_frame;
        end
    end

    assign o_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op.close) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.close) begin
            r_out_det <= acc_w;
            r_out_raw <= raw_w;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.detected_bits  = r_out_det;
    assign o_result.raw_frame_bits = r_out_raw;

endmodule

@@ sv/ir_presence_detector_with_baseline_unit.sv @@
// ----------------------------------------------------------------------------
// ir_presence_detector_with_baseline_unit
// Takes one sample word per cycle while stage 1 is not stalled. The baseline
// sum of the addressed sensor is read from memory at the accept edge and is
// used in stage 1, with the write of the previous word forwarded when it hit
// the same entry. A clear word resets all sums at once through per-entry
// valid bits. A detection word carrying frame end produces one result word;
// it waits in stage 1 only while the previous result is still unread.
// ----------------------------------------------------------------------------
module ir_presence_detector_with_baseline_unit
    import ipd_pkg::*;
#(
    parameter int NUM_SENSORS   = DEF_NUM_SENSORS,
    parameter int CAL_PASSES    = DEF_CAL_PASSES,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THRESH_W-1:0] i_cfg_data,
    ipd_in_if.sink              i_sample,
    ipd_out_if.source           o_result
);

    localparam int ADDR_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int CAL_W  = $clog2(CAL_PASSES + 1);
    localparam int PROD_W = SAMPLE_W + CAL_W;
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    logic [THRESH_W-1:0]    r_thresh;
    logic                   r_s1_valid;
    logic [CMD_W-1:0]       r_s1_cmd;
    logic [SENSOR_W-1:0]    r_s1_idx;
    logic [SAMPLE_W-1:0]    r_s1_sample;
    logic                   r_s1_fend;
    logic [NUM_SENSORS-1:0] r_sum_vld;
    logic                   r_lw_valid;
    logic [ADDR_W-1:0]      r_lw_addr;
    logic [SUM_W-1:0]       r_lw_data;

    logic                   in_accept;
    logic                   out_free;
    logic [SUM_W-1:0]       ram_rdata;
    logic [NUM_SENSORS-1:0] s1_mask;
    logic                   s1_in_range;
    logic [ADDR_W-1:0]      s1_addr;
    logic [SUM_W-1:0]       s1_sum;
    logic [SUM_W:0]         s1_cal_sum;
    logic [SUM_W-1:0]       s1_new_sum;
    logic [SAMPLE_W-1:0]    s1_margin;
    logic [PROD_W-1:0]      s1_limit;
    logic                   s1_det;
    logic                   s1_is_clear;
    logic                   s1_is_cal;
    logic                   s1_is_det;
    logic                   s1_fire;
    logic                   wr_en;
    t_frame_op              frame_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    assign in_accept      = i_sample.valid && i_sample.ready;
    assign i_sample.ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd    <= i_sample.cmd;
            r_s1_idx    <= i_sample.sensor_index;
            r_s1_sample <= i_sample.sample_value;
            r_s1_fend   <= i_sample.frame_end;
        end
    end

    ipd_sum_ram #(
        .DEPTH  (NUM_SENSORS),
        .ADDR_W (ADDR_W)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (s1_new_sum),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_sample.sensor_index[ADDR_W-1:0]),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            s1_mask[i] = (r_s1_idx == SENSOR_W'(i));
        end
    end

    assign s1_in_range = |s1_mask;
    assign s1_addr     = r_s1_idx[ADDR_W-1:0];

    always_comb begin
        if (r_lw_valid && (r_lw_addr == s1_addr)) begin
            s1_sum = r_lw_data;
        end else if (|(r_sum_vld & s1_mask)) begin
            s1_sum = ram_rdata;
        end else begin
            s1_sum = '0;
        end
    end

    assign s1_cal_sum = {1'b0, s1_sum} + (SUM_W+1)'(r_s1_sample);
    assign s1_new_sum = s1_cal_sum[SUM_W] ? SUM_MAX : s1_cal_sum[SUM_W-1:0];

    assign s1_margin = r_s1_sample - r_thresh;
    assign s1_limit  = PROD_W'(s1_margin) * PROD_W'(CAL_PASSES);
    assign s1_det    = (r_s1_sample > r_thresh) && (CMP_W'(s1_sum) < CMP_W'(s1_limit));

    always_comb begin
        s1_is_clear = 1'b0;
        s1_is_cal   = 1'b0;
        s1_is_det   = 1'b0;
        unique case (r_s1_cmd)
            CMD_CLEAR:  s1_is_clear = 1'b1;
            CMD_CAL:    s1_is_cal   = 1'b1;
            CMD_DETECT: s1_is_det   = 1'b1;
            default:    ;
        endcase
    end

    assign s1_fire = r_s1_valid && (!(s1_is_det && r_s1_fend) || out_free);
    assign wr_en   = s1_fire && s1_is_cal && s1_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
        end else if (s1_fire && s1_is_clear) begin
            r_sum_vld <= '0;
        end else if (wr_en) begin
            r_sum_vld <= r_sum_vld | s1_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (s1_fire) begin
            r_lw_valid <= wr_en;
        end else if (!r_s1_valid) begin
            r_lw_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lw_addr <= s1_addr;
            r_lw_data <= s1_new_sum;
        end
    end

    assign frame_op.upd   = s1_fire && s1_is_det && s1_in_range;
    assign frame_op.det   = s1_det;
    assign frame_op.close = s1_fire && s1_is_det && r_s1_fend;

    ipd_frame #(
        .NUM_SENSORS   (NUM_SENSORS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (frame_op),
        .i_mask   (s1_mask),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule

@@ sv/ipd_checker.sv @@
// ----------------------------------------------------------------------------
// ipd_checker
// Port-level checks on the result channel of the presence detector.
// ----------------------------------------------------------------------------
module ipd_checker
    import ipd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_detected,
    input logic [OUT_W-1:0] i_raw
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_raw_in_detected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_raw & ~i_detected) == '0))
        else $error("raw frame bit missing from stretched bits");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_detected) && $stable(i_raw))
        else $error("stalled result word changed");

endmodule

bind ir_presence_detector_with_baseline_unit ipd_checker u_ipd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_detected  (o_result.detected_bits),
    .i_raw       (o_result.raw_frame_bits)
);

@@ dv/ipd_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipd_frame_checker
// Watches the sample and result channels of the IR presence detector. It
// keeps its own copy of the baseline sums, the frame bits, the frame history
// and the threshold, and predicts the frame word that each closing detection
// word must produce. Every result word is compared with the oldest pending
// prediction, field by field. The failure count goes back to the bench top.
// ----------------------------------------------------------------------------
module ipd_frame_checker
    import ipd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THRESH_W-1:0] i_cfg_data,
    ipd_in_if                   i_sample,
    ipd_out_if                  i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    localparam int NUM_SENSORS   = DEF_NUM_SENSORS;
    localparam int CAL_PASSES    = DEF_CAL_PASSES;
    localparam int HISTORY_DEPTH = DEF_HISTORY_DEPTH;

    typedef struct packed {
        logic [OUT_W-1:0] detected_bits;
        logic [OUT_W-1:0] raw_frame_bits;
    } t_frame_word;

    logic [SUM_W-1:0]    baseline_sum [NUM_SENSORS];
    logic [OUT_W-1:0]    open_frame;
    logic [OUT_W-1:0]    past_frames  [HISTORY_DEPTH];
    logic [THRESH_W-1:0] threshold;
    t_frame_word         frame_word_q [$];
    t_frame_word         oldest_word;

    task automatic predict_frame_word(
        input logic [CMD_W-1:0]    cmd,
        input logic [SENSOR_W-1:0] idx,
        input logic [SAMPLE_W-1:0] sample,
        input logic                fend
    );
        logic [SUM_W:0]   sum_next;
        int               excess;
        logic [OUT_W-1:0] stretched;
        t_frame_word      word;
        if (cmd == CMD_CLEAR) begin
            for (int i = 0; i < NUM_SENSORS; i++) baseline_sum[i] = '0;
        end else if (cmd == CMD_CAL) begin
            if (idx < NUM_SENSORS) begin
                sum_next = {1'b0, baseline_sum[idx]} + sample;
                baseline_sum[idx] = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[SUM_W-1:0];
            end
        end else if (cmd == CMD_DETECT) begin
            if (idx < NUM_SENSORS) begin
                excess = int'(sample) - int'(baseline_sum[idx] / CAL_PASSES);
                open_frame[idx] = (excess > int'(threshold));
            end
            if (fend) begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--) past_frames[i] = past_frames[i-1];
                past_frames[0] = open_frame;
                stretched = '0;
                for (int i = 0; i < HISTORY_DEPTH; i++) stretched |= past_frames[i];
                word.detected_bits  = stretched;
                word.raw_frame_bits = open_frame;
                frame_word_q.push_back(word);
                open_frame = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) baseline_sum[i] = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) past_frames[i] = '0;
            open_frame = '0;
            threshold = THRESH_RESET;
            frame_word_q.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (frame_word_q.size() == 0) begin
                    $error("result word with no frame pending: detected_bits %h, raw_frame_bits %h",
                           i_result.detected_bits, i_result.raw_frame_bits);
                    o_fail_count++;
                end else begin
                    oldest_word = frame_word_q.pop_front();
                    if (i_result.detected_bits !== oldest_word.detected_bits) begin
                        $error("detected_bits: expected %h, actual %h",
                               oldest_word.detected_bits, i_result.detected_bits);
                        o_fail_count++;
                    end
                    if (i_result.raw_frame_bits !== oldest_word.raw_frame_bits) begin
                        $error("raw_frame_bits: expected %h, actual %h",
                               oldest_word.raw_frame_bits, i_result.raw_frame_bits);
                        o_fail_count++;
                    end
                    o_checked++;
                end
            end
            if (i_cfg_we) threshold = i_cfg_data;
            if (i_sample.valid && i_sample.ready)
                predict_frame_word(i_sample.cmd, i_sample.sensor_index,
                                   i_sample.sample_value, i_sample.frame_end);
        end
        o_pending = frame_word_q.size();
    end

endmodule

@@ dv/ir_presence_detector_with_baseline_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_presence_detector_with_baseline_unit_tb
// Drives sample words into the IR presence detector: a directed set of edge
// cases, then random sweeps, calibration bursts, saturation bursts, clears
// and noise under several threshold settings and idle patterns, including a
// long result hold-off. The checker predicts and compares; this top gives
// the verdict.
// ----------------------------------------------------------------------------
module ir_presence_detector_with_baseline_unit_tb;
    import ipd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int NUM_SENSORS  = DEF_NUM_SENSORS;
    localparam int PHASE_WORDS  = 380;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [THRESH_W-1:0] cfg_data;

    int send_idle;
    int recv_idle;
    int words_sent;
    int cycles;
    int fail_count;
    int pending;
    int checked;
    int hold_req;
    int hold_done;

    ipd_in_if  sample_if ();
    ipd_out_if result_if ();

    ir_presence_detector_with_baseline_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_if),
        .o_result   (result_if)
    );

    ipd_frame_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_sample     (sample_if),
        .i_result     (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        hold_done = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_req) begin
                hold_done++;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_word(
        input logic [CMD_W-1:0]    cmd,
        input logic [SENSOR_W-1:0] idx,
        input logic [SAMPLE_W-1:0] sample,
        input logic                fend
    );
        while ($urandom_range(99) < send_idle) begin
            sample_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.cmd          <= cmd;
        sample_if.sensor_index <= idx;
        sample_if.sample_value <= sample;
        sample_if.frame_end    <= fend;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd != CMD_NONE) words_sent++;
    endtask

    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_word(CMD_DETECT, 5'd0,  10'd1023, 1'b0);
        send_word(CMD_DETECT, 5'd23, 10'd0,    1'b0);
        send_word(CMD_CAL,    5'd3,  10'd1023, 1'b1);
        send_word(CMD_NONE,   5'd7,  10'd1023, 1'b1);
        send_word(CMD_DETECT, 5'd1,  10'd110,  1'b0);
        send_word(CMD_DETECT, 5'd2,  10'd111,  1'b0);
        send_word(CMD_CAL,    5'd4,  10'd1023, 1'b0);
        send_word(CMD_DETECT, 5'd4,  10'd10,   1'b0);
        send_word(CMD_DETECT, 5'd3,  10'd200,  1'b0);
        send_word(CMD_CAL,    5'd24, 10'd1023, 1'b0);
        send_word(CMD_CAL,    5'd31, 10'd0,    1'b0);
        send_word(CMD_DETECT, 5'd31, 10'd1023, 1'b1);
        send_word(CMD_CLEAR,  5'd31, 10'd1023, 1'b1);
        send_word(CMD_DETECT, 5'd3,  10'd200,  1'b0);
        send_word(CMD_DETECT, 5'd4,  10'd1023, 1'b0);
        send_word(CMD_DETECT, 5'd23, 10'd1023, 1'b1);
        send_word(CMD_DETECT, 5'd0,  10'd0,    1'b1);
        send_word(CMD_DETECT, 5'd24, 10'd1023, 1'b1);
        send_word(CMD_CLEAR,  5'd0,  10'd0,    1'b0);
        send_word(CMD_DETECT, 5'd5,  10'd500,  1'b1);
    endtask

    task automatic run_random(input int count);
        int target;
        int pick;
        int len;
        int hot;
        target = words_sent + count;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                for (int s = 0; s < NUM_SENSORS; s++)
                    send_word(CMD_DETECT, SENSOR_W'(s), SAMPLE_W'($urandom_range(1023)),
                              s == NUM_SENSORS - 1);
            end else if (pick < 55) begin
                len = $urandom_range(1, NUM_SENSORS);
                for (int s = 0; s < len; s++)
                    send_word(CMD_DETECT, SENSOR_W'($urandom_range(NUM_SENSORS - 1)),
                              SAMPLE_W'($urandom_range(1023)), s == len - 1);
            end else if (pick < 75) begin
                len = $urandom_range(1, 16);
                for (int s = 0; s < len; s++)
                    send_word(CMD_CAL, SENSOR_W'($urandom_range(NUM_SENSORS - 1)),
                              SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
            end else if (pick < 79) begin
                hot = $urandom_range(NUM_SENSORS - 1);
                for (int s = 0; s < 70; s++)
                    send_word(CMD_CAL, SENSOR_W'(hot), SAMPLE_W'($urandom_range(900, 1023)),
                              1'b0);
                send_word(CMD_DETECT, SENSOR_W'(hot), 10'd1023, 1'b1);
            end else if (pick < 85) begin
                send_word(CMD_CLEAR, SENSOR_W'($urandom_range(31)),
                          SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
            end else begin
                len = $urandom_range(1, 4);
                for (int s = 0; s < len; s++)
                    send_word(CMD_W'($urandom_range(3)), SENSOR_W'($urandom_range(31)),
                              SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        sample_if.valid        = 1'b0;
        sample_if.cmd          = CMD_CLEAR;
        sample_if.sensor_index = '0;
        sample_if.sample_value = '0;
        sample_if.frame_end    = 1'b0;
        cfg_we                 = 1'b0;
        cfg_data               = '0;
        i_rst_n                = 1'b0;
        send_idle              = 0;
        recv_idle              = 0;
        words_sent             = 0;
        hold_req               = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        write_threshold('0);
        send_idle = 27;
        recv_idle = 82;
        run_random(PHASE_WORDS);

        write_threshold('1);
        send_idle = 82;
        recv_idle = 27;
        run_random(PHASE_WORDS);

        write_threshold(THRESH_W'($urandom_range(1, 1022)));
        send_idle = 0;
        recv_idle = 0;
        hold_req++;
        run_random(PHASE_WORDS / 2);

        // pause the sender until every frame word is back
        write_threshold(THRESH_RESET);
        run_random(PHASE_WORDS / 2);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d sample words over five threshold settings and three idle patterns.",
                 words_sent);
        $display("Compared %0d frame words, including a long result hold-off.", checked);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
